// ----- rtl/dcf_pkg.sv -----
// constants, types and helper functions for the date calendar fields core
// no dependencies; imported by date_calendar_fields_core
package dcf_pkg;

   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned DOY_W   = 9;
   localparam int unsigned WDAY_W  = 3;
   localparam int unsigned WEEK_W  = 6;

   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 24;

   localparam logic [YEAR_W-1:0] YEAR_MAX    = 14'd9999;
   localparam logic [YEAR_W-1:0] YEAR_SWITCH = 14'd1752;
   localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_SEP  = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
   localparam logic [DAY_W-1:0] SKIP_FIRST   = 5'd3;
   localparam logic [DAY_W-1:0] SKIP_LAST    = 5'd13;

   // floor(y/100) = (y * 5243) >> 19, exact for y below 16384
   localparam int unsigned RECIP100_W     = 13;
   localparam logic [RECIP100_W-1:0] RECIP100 = 13'd5243;
   localparam int unsigned RECIP100_SHIFT = 19;

   // floor(x/7) = (x * 2341) >> 14, exact for x below 512
   localparam int unsigned RECIP7_W     = 12;
   localparam logic [RECIP7_W-1:0] RECIP7 = 12'd2341;
   localparam int unsigned RECIP7_SHIFT = 14;

   typedef logic [14:0] wsum_type;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   typedef struct packed {
      logic              valid_res;
      logic              leap;
      logic [DOY_W-1:0]  day_of_year;
      logic [WDAY_W-1:0] weekday;
      logic [WEEK_W-1:0] week_of_year;
   } fields_type;

   // days in month, february taken as 28
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // days before the month in a common year
   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] n;
      case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

   // zeller month term ((zm + 1) * 13) / 5, jan and feb as months 13 and 14
   function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] m);
      logic [5:0] t;
      case (m)
         4'd1:    t = 6'd36;
         4'd2:    t = 6'd39;
         4'd3:    t = 6'd10;
         4'd4:    t = 6'd13;
         4'd5:    t = 6'd15;
         4'd6:    t = 6'd18;
         4'd7:    t = 6'd20;
         4'd8:    t = 6'd23;
         4'd9:    t = 6'd26;
         4'd10:   t = 6'd28;
         4'd11:   t = 6'd31;
         4'd12:   t = 6'd33;
         default: t = 6'd0;
      endcase
      return t;
   endfunction

   function automatic logic [6:0] div100(input logic [YEAR_W-1:0] y);
      logic [YEAR_W+RECIP100_W-1:0] prod;
      prod = {{RECIP100_W{1'b0}}, y} * {{YEAR_W{1'b0}}, RECIP100};
      return prod[RECIP100_SHIFT+6:RECIP100_SHIFT];
   endfunction

   function automatic logic [WEEK_W-1:0] div7(input logic [DOY_W-1:0] x);
      logic [DOY_W+RECIP7_W-1:0] prod;
      prod = {{RECIP7_W{1'b0}}, x} * {{DOY_W{1'b0}}, RECIP7};
      return prod[RECIP7_SHIFT+WEEK_W-1:RECIP7_SHIFT];
   endfunction

   // 8 = 1 mod 7, so octal digits are summed and folded
   function automatic logic [WDAY_W-1:0] mod7(input wsum_type s);
      logic [5:0] t;
      logic [3:0] f;
      logic [3:0] r;
      t = {3'd0, s[2:0]} + {3'd0, s[5:3]} + {3'd0, s[8:6]}
        + {3'd0, s[11:9]} + {3'd0, s[14:12]};
      f = {1'b0, t[5:3]} + {1'b0, t[2:0]};
      r = (f >= 4'd7) ? f - 4'd7 : f;
      return r[WDAY_W-1:0];
   endfunction

endpackage

// ----- rtl/date_calendar_fields_core.sv -----
// date calendar fields core: validity, leap flag, ordinal day, weekday, week
//
// Usage:
//   req channel carries one date per beat: day, month and year. Every beat
//   gives exactly one rsp beat, in order. rsp_tuser is 1 for a date that
//   exists; otherwise it is 0 and all of rsp_tdata is zero.
//   Weekday follows zeller's congruence with 0 for saturday; dates up to
//   2 september 1752 use the julian form, later dates the gregorian form.
//   The leap flag and february length always use the gregorian rule.
//
// Pipeline and throughput:
//   a beat accepted on req passes the input register, then the result register,
//   and then appears on rsp. One beat is taken per cycle for as long as rsp
//   drains; the only loop is the ready path through the two registers.
//
// Reset and stalls:
//   reset empties both registers. When rsp_tready is low the result holds,
//   the input register still fills, and req_tready drops only once both
//   registers are full.
//
// depends on dcf_pkg
module date_calendar_fields_core
   import dcf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // day[4:0], month[8:5], year[22:9], zero fill
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // leap[0], day_of_year[9:1], weekday[12:10],
                                             // week_of_year[18:13], zero fill
   output logic                  rsp_tuser   // valid_res
);

   logic       s1_valid_ff, s1_valid_in;
   date_type   s1_date_ff, s1_date_in;
   logic       rsp_valid_ff, rsp_valid_in;
   fields_type rsp_fields_ff, rsp_fields_in;

   logic rsp_load;

   // calculation signals
   logic [DAY_W-1:0]   d;
   logic [MONTH_W-1:0] m;
   logic [YEAR_W-1:0]  y;
   logic [6:0]         q100;
   logic [YEAR_W-1:0]  r100;
   logic               leap;
   logic [DAY_W-1:0]   dmax;
   logic               ok;
   logic               early;
   logic               greg;
   logic [6:0]         qyy;
   logic [YEAR_W-1:0]  yy_g;
   wsum_type           yy_j;
   wsum_type           sum_g;
   wsum_type           sum_j;
   logic [DOY_W-1:0]   doy0;
   logic [DOY_W-1:0]   doy1;
   logic [WEEK_W-1:0]  week0;
   logic [WEEK_W-1:0]  week1;

   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || rsp_load;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_date_in  = s1_date_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         s1_date_in.day   = req_tdata[4:0];
         s1_date_in.month = req_tdata[8:5];
         s1_date_in.year  = req_tdata[22:9];
      end
   end

   always_comb begin
      d = s1_date_ff.day;
      m = s1_date_ff.month;
      y = s1_date_ff.year;

      q100 = div100(y);
      r100 = y - ({7'd0, q100} * 14'd100);
      leap = (y[1:0] == 2'd0) && ((r100 != 14'd0) || (q100[1:0] == 2'd0));

      dmax = (m == MONTH_FEB) ? (leap ? 5'd29 : 5'd28) : month_len(m);
      ok = (y <= YEAR_MAX) && (m != 4'd0) && (m <= MONTH_DEC)
         && (d != 5'd0) && (d <= dmax)
         && !((y == YEAR_SWITCH) && (m == MONTH_SEP)
              && (d >= SKIP_FIRST) && (d <= SKIP_LAST));

      early = (m < 4'd3);
      greg  = (y > YEAR_SWITCH)
            || ((y == YEAR_SWITCH) && ((m > MONTH_SEP) || ((m == MONTH_SEP) && (d > SKIP_LAST))));

      // jan and feb count in the previous year; its century quotient drops
      // by one only when the year is a multiple of 100
      yy_g = early ? y - 14'd1 : y;
      qyy  = (early && (r100 == 14'd0)) ? q100 - 7'd1 : q100;
      sum_g = {10'd0, d} + {9'd0, month_term(m)} + {1'b0, yy_g} + {3'd0, yy_g[13:2]}
            - {8'd0, qyy} + {10'd0, qyy[6:2]};

      // julian form shifted by 28 years so the previous year never goes negative
      yy_j  = {1'b0, y} + 15'd28 - (early ? 15'd1 : 15'd0);
      sum_j = {10'd0, d} + {9'd0, month_term(m)} + yy_j + {2'd0, yy_j[14:2]} + 15'd5;

      // both leap outcomes are formed so the week divide does not wait on leap
      doy0  = days_before(m) + {4'd0, d};
      doy1  = doy0 + ((m > MONTH_FEB) ? 9'd1 : 9'd0);
      week0 = div7(doy0 + 9'd6);
      week1 = div7(doy1 + 9'd6);

      rsp_fields_in = '0;
      if (ok) begin
         rsp_fields_in.valid_res    = 1'b1;
         rsp_fields_in.leap         = leap;
         rsp_fields_in.day_of_year  = leap ? doy1 : doy0;
         rsp_fields_in.weekday      = greg ? mod7(sum_g) : mod7(sum_j);
         rsp_fields_in.week_of_year = leap ? week1 : week0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_date_ff <= s1_date_in;
      if (rsp_load && s1_valid_ff) begin
         rsp_fields_ff <= rsp_fields_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_fields_ff.valid_res;
   assign rsp_tdata  = {5'd0,
                        rsp_fields_ff.week_of_year,
                        rsp_fields_ff.weekday,
                        rsp_fields_ff.day_of_year,
                        rsp_fields_ff.leap};

endmodule

// ----- tb/date_calendar_fields_core_tb.sv -----
// self-checking testbench for date_calendar_fields_core: directed dates, then random dates
// predicted by a local calendar model; depends on dcf_pkg and the core rtl
`timescale 1ns / 1ps

module date_calendar_fields_core_tb;
   import dcf_pkg::*;

   localparam int N_DIRECTED  = 25;
   localparam int N_PER_PHASE = 250;
   localparam int CYCLE_LIMIT = 100000;
   localparam fields_type NO_DATE = '0;

   typedef struct {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      bit                 typed;   // expected result written in the row
      fields_type         want;
   } date_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   fields_type fields_expect_q[$];
   int         send_idle_pct = 0;
   int         take_idle_pct = 0;
   int         mismatches = 0;
   int         dates_sent = 0;
   int         results_seen = 0;
   int         valid_seen = 0;
   int         cycle_count = 0;

   date_calendar_fields_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   date_row_type directed_rows [N_DIRECTED] = '{
      '{5'd0,  4'd1,  14'd2000,  1'b1, NO_DATE},
      '{5'd31, 4'd0,  14'd2000,  1'b1, NO_DATE},
      '{5'd1,  4'd13, 14'd2000,  1'b1, NO_DATE},
      '{5'd31, 4'd15, 14'd16383, 1'b1, NO_DATE},
      '{5'd1,  4'd1,  14'd10000, 1'b1, NO_DATE},
      '{5'd0,  4'd0,  14'd0,     1'b1, NO_DATE},
      '{5'd29, 4'd2,  14'd1900,  1'b1, NO_DATE},
      '{5'd29, 4'd2,  14'd2023,  1'b1, NO_DATE},
      '{5'd30, 4'd2,  14'd2024,  1'b1, NO_DATE},
      '{5'd31, 4'd4,  14'd2024,  1'b1, NO_DATE},
      '{5'd3,  4'd9,  14'd1752,  1'b1, NO_DATE},
      '{5'd13, 4'd9,  14'd1752,  1'b1, NO_DATE},
      '{5'd1,  4'd1,  14'd2000,  1'b1, '{1'b1, 1'b1, 9'd1, 3'd0, 6'd1}},
      '{5'd31, 4'd12, 14'd2024,  1'b1, '{1'b1, 1'b1, 9'd366, 3'd3, 6'd53}},
      '{5'd2,  4'd9,  14'd1752,  1'b0, NO_DATE},
      '{5'd14, 4'd9,  14'd1752,  1'b0, NO_DATE},
      '{5'd31, 4'd12, 14'd1752,  1'b0, NO_DATE},
      '{5'd1,  4'd1,  14'd0,     1'b0, NO_DATE},
      '{5'd29, 4'd2,  14'd0,     1'b0, NO_DATE},
      '{5'd1,  4'd3,  14'd0,     1'b0, NO_DATE},
      '{5'd31, 4'd12, 14'd0,     1'b0, NO_DATE},
      '{5'd1,  4'd1,  14'd9999,  1'b0, NO_DATE},
      '{5'd31, 4'd12, 14'd9999,  1'b0, NO_DATE},
      '{5'd29, 4'd2,  14'd2000,  1'b0, NO_DATE},
      '{5'd28, 4'd2,  14'd1753,  1'b0, NO_DATE}
   };

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit gregorian_leap(input int yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   function automatic int days_in_month(input int mon, input int yr);
      case (mon)
         2:           return gregorian_leap(yr) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   function automatic fields_type calendar_fields_of(input logic [DAY_W-1:0] d,
                                                     input logic [MONTH_W-1:0] m,
                                                     input logic [YEAR_W-1:0] y);
      fields_type f;
      int dd, mm, yy, zy, doy, mterm, wd, i;
      bit greg;
      f  = '0;
      dd = d;
      mm = m;
      yy = y;
      if (yy > 9999 || mm < 1 || mm > 12) return f;
      if (dd < 1 || dd > days_in_month(mm, yy)) return f;
      // days dropped at the julian to gregorian switch
      if (yy == 1752 && mm == 9 && dd > 2 && dd < 14) return f;
      doy = dd;
      for (i = 1; i < mm; i++) doy += days_in_month(i, yy);
      // jan and feb count as months 13 and 14 of the year before
      mterm = ((((mm < 3) ? mm + 12 : mm) + 1) * 13) / 5;
      greg = (yy > 1752) || (yy == 1752 && (mm > 9 || (mm == 9 && dd >= 14)));
      if (greg) begin
         zy = (mm < 3) ? yy - 1 : yy;
         wd = (dd + mterm + zy + zy / 4 - zy / 100 + zy / 400) % 7;
      end else begin
         // 28 year julian cycle keeps year 0 january nonnegative
         zy = yy + 28 - ((mm < 3) ? 1 : 0);
         wd = (dd + mterm + zy + zy / 4 + 5) % 7;
      end
      f.valid_res    = 1'b1;
      f.leap         = gregorian_leap(yy);
      f.day_of_year  = DOY_W'(doy);
      f.weekday      = WDAY_W'(wd);
      f.week_of_year = WEEK_W'((doy + 6) / 7);
      return f;
   endfunction

   // one req beat; the expectation is queued at the accepting edge
   task automatic send_date(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                            input logic [YEAR_W-1:0] y, input fields_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, y, m, d};
      do @(posedge clock); while (!req_tready);
      fields_expect_q.push_back(want);
      dates_sent++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   always @(posedge clock) begin
      fields_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.valid_res    = rsp_tuser;
         got.leap         = rsp_tdata[0];
         got.day_of_year  = rsp_tdata[9:1];
         got.weekday      = rsp_tdata[12:10];
         got.week_of_year = rsp_tdata[18:13];
         results_seen++;
         if (got.valid_res) valid_seen++;
         if (fields_expect_q.size() == 0) begin
            $error("rsp beat with no date outstanding");
            mismatches++;
         end else begin
            want = fields_expect_q.pop_front();
            if (got.valid_res !== want.valid_res) begin
               $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
               mismatches++;
            end
            if (got.leap !== want.leap) begin
               $error("leap: expected %0d, got %0d", want.leap, got.leap);
               mismatches++;
            end
            if (got.day_of_year !== want.day_of_year) begin
               $error("day_of_year: expected %0d, got %0d", want.day_of_year, got.day_of_year);
               mismatches++;
            end
            if (got.weekday !== want.weekday) begin
               $error("weekday: expected %0d, got %0d", want.weekday, got.weekday);
               mismatches++;
            end
            if (got.week_of_year !== want.week_of_year) begin
               $error("week_of_year: expected %0d, got %0d", want.week_of_year,
                      got.week_of_year);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      logic [DAY_W-1:0]   d;
      logic [MONTH_W-1:0] m;
      logic [YEAR_W-1:0]  y;
      int phase, n, pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 26;
      take_idle_pct = 56;
      for (n = 0; n < N_DIRECTED; n++) begin
         d = directed_rows[n].day;
         m = directed_rows[n].month;
         y = directed_rows[n].year;
         send_date(d, m, y, directed_rows[n].typed ? directed_rows[n].want
                                                   : calendar_fields_of(d, m, y));
      end

      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 56 : 0;
         take_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 26 : 0;
         for (n = 0; n < N_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
               // raw noise over the full field widths
               d = DAY_W'($urandom_range(31));
               m = MONTH_W'($urandom_range(15));
               y = YEAR_W'($urandom_range(16383));
            end else begin
               case ($urandom_range(4))
                  0:       y = YEAR_W'($urandom_range(9999));
                  1:       y = YEAR_W'($urandom_range(1745, 1760));
                  2:       y = YEAR_W'(100 * $urandom_range(99) + $urandom_range(1) * 4);
                  3:       y = YEAR_W'($urandom_range(40));
                  default: y = YEAR_W'($urandom_range(9960, 9999));
               endcase
               m = MONTH_W'($urandom_range(1, 12));
               if (y == 1752 && $urandom_range(1)) m = 4'd9;
               d = DAY_W'($urandom_range(1, days_in_month(m, y)));
               // push some dates one past the end of the month
               if (pick < 20) d = DAY_W'(days_in_month(m, y) + 1);
            end
            send_date(d, m, y, calendar_fields_of(d, m, y));
         end
      end
      req_tvalid <= 1'b0;

      while (fields_expect_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("summary: %0d dates sent, %0d results checked (%0d existing dates), %0d errors",
               dates_sent, results_seen, valid_seen, mismatches);
      $display("summary: covered calendar switch, leap rules, bad fields, three idle mixes");
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/dcf_pkg.sv
rtl/date_calendar_fields_core.sv
tb/date_calendar_fields_core_tb.sv
